FILE: rtl/core/itaf_pkg.sv
// Package: shared types, character constants and digit-to-ASCII mapping.
`default_nettype none

package itaf_pkg;

  // Opcodes of the input word
  localparam logic [1:0] OP_SDEC = 2'd0;
  localparam logic [1:0] OP_UDEC = 2'd1;
  localparam logic [1:0] OP_HEXL = 2'd2;
  localparam logic [1:0] OP_HEXU = 2'd3;

  // Sizes
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DEC_DIGITS  = 10;
  localparam int unsigned CNT_W       = 5;

  // Reciprocal of ten: floor(x * RECIP10 / 2^35) == x / 10 for any 32-bit x
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEX,
    ST_DMUL,
    ST_DDIV,
    ST_EMIT
  } state_e;

  typedef logic [CNT_W-1:0] count_t;

  // Map one digit value to its ASCII code
  function automatic logic [7:0] digit_char(logic [3:0] digit, logic upper);
    logic [7:0] base;
    if (digit < 4'd10) begin
      digit_char = CHAR_ZERO + {4'b0, digit};
    end else begin
      base       = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      digit_char = base + {4'b0, digit} - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/itaf_if.sv
// Interfaces: input word channel and character output channel.
`default_nettype none

interface itaf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface itaf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;
  logic [4:0] char_count;

  modport source (output valid, output char_code, output is_last, output char_count,
                  input ready);
  modport sink   (input valid, input char_code, input is_last, input char_count,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/itaf_div10.sv
// Divide-by-ten unit: registered reciprocal multiply, quotient and remainder.
`default_nettype none

module itaf_div10 (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] dividend_i,
  output logic      [31:0] quot_o,
  output logic      [3:0]  rem_o
);

  logic [63:0] prod_d, prod_q;
  logic [31:0] times_ten;

  // Reciprocal multiply, registered before use
  assign prod_d = {32'b0, dividend_i} * {32'b0, itaf_pkg::RECIP10};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // Quotient from the high product bits; remainder by shift-and-add back-multiply
  assign quot_o    = {3'b0, prod_q[63:itaf_pkg::RECIP_SHIFT]};
  assign times_ten = (quot_o << 3) + (quot_o << 1);

  logic [31:0] rem_full;
  assign rem_full = dividend_i - times_ten;
  assign rem_o    = rem_full[3:0];

endmodule

`default_nettype wire

FILE: rtl/core/integer_to_ascii_formatter.sv
// Top level: integer to ASCII formatter (signed/unsigned decimal, hex).
//
// Usage: one input word (opcode, value) enters on in_i when the block is idle.
// The digits are extracted least significant first into a 16-entry digit
// stack, then popped and sent on out_o most significant first, one character
// per word. The final word carries is_last and the total character count;
// char_count is zero on all earlier words. A negative signed decimal value
// gets a leading '-'. Hex extracts one digit per cycle (shift unit); decimal
// extracts each digit through ST_DMUL (registered reciprocal multiply), then
// ST_DDIV (remainder and push). Each character is then offered on out_o
// until taken; after the last one the block returns to idle and takes the
// next word.
// in_i.ready is high only while idle. When the receiver holds out_o.ready low,
// the current character and all state hold. Reset returns to idle with no
// output word pending.
`default_nettype none

module integer_to_ascii_formatter (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  itaf_in_if.sink     in_i,
  itaf_out_if.source  out_o
);

  itaf_pkg::state_e state_q, state_d;

  logic [63:0]      val_q, val_d;
  logic [31:0]      mag_q, mag_d;
  logic             neg_q, neg_d;
  logic             upper_q, upper_d;
  itaf_pkg::count_t nd_q, nd_d;
  itaf_pkg::count_t total_q, total_d;
  itaf_pkg::count_t left_q, left_d;
  logic [3:0]       stk_q [itaf_pkg::STACK_DEPTH];
  logic [3:0]       stk_d [itaf_pkg::STACK_DEPTH];

  logic [31:0]      quot;
  logic [3:0]       rem;
  logic             push;
  logic             pop;
  logic [3:0]       push_digit;
  logic [31:0]      in_mag;
  logic             in_neg;
  logic [63:0]      val_shift;
  itaf_pkg::count_t nd_inc;

  // Divide-by-ten unit for decimal digit extraction
  itaf_div10 u_div10 (
    .clk_i      (clk_i),
    .en_i       (state_q == itaf_pkg::ST_DMUL),
    .dividend_i (mag_q),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign in_mag    = in_i.value[31:0];
  assign in_neg    = (in_i.opcode == itaf_pkg::OP_SDEC) && in_mag[31];
  assign val_shift = val_q >> 4;
  assign nd_inc    = nd_q + itaf_pkg::count_t'(1);

  // Sequencer: next state and datapath control
  always_comb begin
    state_d    = state_q;
    val_d      = val_q;
    mag_d      = mag_q;
    neg_d      = neg_q;
    upper_d    = upper_q;
    nd_d       = nd_q;
    total_d    = total_q;
    left_d     = left_q;
    push       = 1'b0;
    pop        = 1'b0;
    push_digit = 4'd0;
    in_i.ready = 1'b0;

    case (state_q)
      itaf_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          nd_d    = '0;
          val_d   = in_i.value;
          upper_d = (in_i.opcode == itaf_pkg::OP_HEXU);
          neg_d   = in_neg;
          // two's complement negate; the most negative value maps onto itself
          mag_d   = in_neg ? (~in_mag + 32'd1) : in_mag;
          if (in_i.opcode inside {itaf_pkg::OP_HEXL, itaf_pkg::OP_HEXU}) begin
            state_d = itaf_pkg::ST_HEX;
          end else begin
            state_d = itaf_pkg::ST_DMUL;
          end
        end
      end

      itaf_pkg::ST_HEX: begin
        push       = 1'b1;
        push_digit = val_q[3:0];
        val_d      = val_shift;
        nd_d       = nd_inc;
        if (val_shift == 64'd0 || nd_inc == itaf_pkg::count_t'(itaf_pkg::STACK_DEPTH)) begin
          total_d = nd_inc;
          left_d  = nd_inc;
          state_d = itaf_pkg::ST_EMIT;
        end
      end

      itaf_pkg::ST_DMUL: begin
        state_d = itaf_pkg::ST_DDIV;
      end

      itaf_pkg::ST_DDIV: begin
        push       = 1'b1;
        push_digit = rem;
        mag_d      = quot;
        nd_d       = nd_inc;
        if (quot == 32'd0 || nd_inc == itaf_pkg::count_t'(itaf_pkg::DEC_DIGITS)) begin
          total_d = nd_inc + itaf_pkg::count_t'(neg_q);
          left_d  = nd_inc + itaf_pkg::count_t'(neg_q);
          state_d = itaf_pkg::ST_EMIT;
        end else begin
          state_d = itaf_pkg::ST_DMUL;
        end
      end

      itaf_pkg::ST_EMIT: begin
        if (out_o.ready) begin
          // the sign goes out first, digits follow from the stack top
          if (neg_q) begin
            neg_d = 1'b0;
          end else begin
            pop = 1'b1;
          end
          left_d = left_q - itaf_pkg::count_t'(1);
          if (left_q == itaf_pkg::count_t'(1)) begin
            state_d = itaf_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_d = itaf_pkg::ST_IDLE;
      end
    endcase
  end

  // Digit stack: push at entry 0 shifting up, pop shifting down
  always_comb begin
    for (int i = 0; i < itaf_pkg::STACK_DEPTH; i++) begin
      stk_d[i] = stk_q[i];
      if (push) begin
        stk_d[i] = (i == 0) ? push_digit : stk_q[(i == 0) ? 0 : i - 1];
      end else if (pop) begin
        stk_d[i] = (i == itaf_pkg::STACK_DEPTH - 1) ? 4'd0
                 : stk_q[(i == itaf_pkg::STACK_DEPTH - 1) ? i : i + 1];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itaf_pkg::ST_IDLE;
      neg_q   <= 1'b0;
      left_q  <= '0;
      nd_q    <= '0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
      left_q  <= left_d;
      nd_q    <= nd_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    mag_q   <= mag_d;
    upper_q <= upper_d;
    total_q <= total_d;
    stk_q   <= stk_d;
  end

  // Output word
  assign out_o.valid      = (state_q == itaf_pkg::ST_EMIT);
  assign out_o.char_code  = neg_q ? itaf_pkg::CHAR_MINUS
                                  : itaf_pkg::digit_char(stk_q[0], upper_q);
  assign out_o.is_last    = (left_q == itaf_pkg::count_t'(1));
  assign out_o.char_count = out_o.is_last ? total_q : itaf_pkg::count_t'(0);

endmodule

`default_nettype wire
